// File: sv/rxff_pkg.sv
// ---------------------------------------------------------------------------
// rxff_pkg
// Shared constants and controller/datapath interface types for the UART
// receive FIFO with XON/XOFF flow control.
// ---------------------------------------------------------------------------
`default_nettype none

package rxff_pkg;

    localparam int unsigned DEPTH_DEFAULT = 256;

    localparam logic [7:0] XON_BYTE        = 8'h11;
    localparam logic [7:0] XOFF_BYTE       = 8'h13;
    localparam logic [7:0] HIGH_MARK_RESET = 8'd64;
    localparam logic [7:0] LOW_MARK_RESET  = 8'd8;

    localparam int unsigned APB_AW = 3;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam logic REG_HIGH_MARK = 1'b0;
    localparam logic REG_LOW_MARK  = 1'b1;

    typedef struct packed {
        logic accept;
        logic capture;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
    } t_dp_status;

endpackage

`default_nettype wire

// File: sv/rxff_ctrl.sv
// ---------------------------------------------------------------------------
// rxff_ctrl
// Transaction sequencer: accepts one item, waits on the buffer read for a
// pop from a non-empty buffer, then holds the result until the output side takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module rxff_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic                i_kind,
    output logic                     o_stall,
    output logic                     o_valid,
    input  wire logic                i_stall,
    input  wire rxff_pkg::t_dp_status i_status,
    output rxff_pkg::t_dp_cmd        o_cmd
);
    import rxff_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept        = (r_state == S_IDLE) && i_valid;
    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_cmd.accept  = accept;
    assign o_cmd.capture = (r_state == S_READ);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if ((i_kind == KIND_POP) && !i_status.empty) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_READ: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: sv/rxff_dp.sv
// ---------------------------------------------------------------------------
// rxff_dp
// Ring buffer datapath: byte memory, pointers, fill count, watermark
// compares and the registered result.
// ---------------------------------------------------------------------------
`default_nettype none

module rxff_dp #(
    parameter int unsigned DEPTH = rxff_pkg::DEPTH_DEFAULT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire rxff_pkg::t_dp_cmd    i_cmd,
    output rxff_pkg::t_dp_status      o_status,
    input  wire logic                 i_kind,
    input  wire logic [7:0]           i_rx_byte,
    input  wire logic [7:0]           i_high_mark,
    input  wire logic [7:0]           i_low_mark,
    output logic                      o_data_valid,
    output logic [7:0]                o_data_byte,
    output logic                      o_flow_send,
    output logic [7:0]                o_flow_byte,
    output logic                      o_overflow,
    output logic [7:0]                o_fill_level
);
    import rxff_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = (AW > 8) ? AW : 8;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW-1:0] r_count;

    logic [AW-1:0] n_count;
    logic [CW-1:0] fill_ext;
    logic          full;
    logic          empty;
    logic          do_push;
    logic          do_pop;
    logic          xoff;
    logic          xon;

    assign full    = (r_count == LAST);
    assign empty   = (r_count == '0);
    assign do_push = i_cmd.accept && (i_kind == KIND_PUSH) && !full;
    assign do_pop  = i_cmd.accept && (i_kind == KIND_POP) && !empty;

    assign o_status.empty = empty;

    always_comb begin
        n_count = r_count;
        if (do_push) begin
            n_count = r_count + 1'b1;
        end else if (do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    assign fill_ext = CW'(n_count);
    assign xoff     = (i_kind == KIND_PUSH) && (fill_ext > CW'(i_high_mark));
    assign xon      = (i_kind == KIND_POP) && !empty && (fill_ext < CW'(i_low_mark));

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rx_byte;
        end
        r_rd_data <= r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            o_data_valid <= do_pop;
            o_data_byte  <= 8'h00;
            o_flow_send  <= xoff || xon;
            o_flow_byte  <= xoff ? XOFF_BYTE : (xon ? XON_BYTE : 8'h00);
            o_overflow   <= (i_kind == KIND_PUSH) && full;
            o_fill_level <= (fill_ext > CW'(8'hFF)) ? 8'hFF : fill_ext[7:0];
        end else if (i_cmd.capture) begin
            o_data_byte  <= r_rd_data;
        end
    end

endmodule

`default_nettype wire

// File: sv/rx_fifo_xon_xoff_flow_core.sv
// ---------------------------------------------------------------------------
// rx_fifo_xon_xoff_flow_core
// UART receive FIFO with XON/XOFF software flow control and APB watermarks.
// ---------------------------------------------------------------------------
// Sequence: the result is registered at accept and shown in S_OUT for a push
//   or an empty pop; a pop that reads the buffer passes S_READ first (registered memory read).
// Transactions: a new one is taken only after the last result has left S_OUT,
//   so a stalled result also holds off the next transaction.
// Reset: clears pointers, fill count and state; marks return to 64 and 8.
//   Buffer contents are not cleared and need no clearing pass.
`default_nettype none

module rx_fifo_xon_xoff_flow_core #(
    parameter int unsigned DEPTH = rxff_pkg::DEPTH_DEFAULT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rxff_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_kind,
    input  wire logic [7:0]                  i_rx_byte,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic                             o_data_valid,
    output logic [7:0]                       o_data_byte,
    output logic                             o_flow_send,
    output logic [7:0]                       o_flow_byte,
    output logic                             o_overflow,
    output logic [7:0]                       o_fill_level
);
    import rxff_pkg::*;

    logic [7:0] r_high_mark;
    logic [7:0] r_low_mark;
    logic       cfg_wr;
    t_dp_cmd    cmd;
    t_dp_status status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_mark <= HIGH_MARK_RESET;
            r_low_mark  <= LOW_MARK_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_HIGH_MARK) begin
                r_high_mark <= pwdata[7:0];
            end else begin
                r_low_mark <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_HIGH_MARK) ? {24'h0, r_high_mark}
                                                : {24'h0, r_low_mark};

    rxff_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_kind   (i_kind),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    rxff_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_kind       (i_kind),
        .i_rx_byte    (i_rx_byte),
        .i_high_mark  (r_high_mark),
        .i_low_mark   (r_low_mark),
        .o_data_valid (o_data_valid),
        .o_data_byte  (o_data_byte),
        .o_flow_send  (o_flow_send),
        .o_flow_byte  (o_flow_byte),
        .o_overflow   (o_overflow),
        .o_fill_level (o_fill_level)
    );

endmodule

`default_nettype wire

// File: tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the UART receive FIFO with XON/XOFF flow control.
// Pushes and drain ticks go in through the valid/stall input channel. A
// behavioral FIFO predicts each result, and the monitor checks every result
// field against it. Watermarks are reprogrammed over APB between phases.
// Phases cover directed corners, fill-to-overflow and drain-to-empty bursts,
// and random push/pop mixes with random source gaps and sink stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rxff_pkg::*;

    localparam int unsigned FIFO_DEPTH = DEPTH_DEFAULT;
    localparam int unsigned STUCK_LIMIT = 2000;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_rx_item;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic       flow_send;
        logic [7:0] flow_byte;
        logic       overflow;
        logic [7:0] fill_level;
    } t_rx_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_kind = KIND_PUSH;
    logic [7:0]        i_rx_byte = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic              o_data_valid;
    logic [7:0]        o_data_byte;
    logic              o_flow_send;
    logic [7:0]        o_flow_byte;
    logic              o_overflow;
    logic [7:0]        o_fill_level;

    t_rx_item    rx_items[$];
    t_rx_result  pending_results[$];
    t_rx_item    next_item;

    logic [7:0]  ring_copy[FIFO_DEPTH];
    int unsigned wr_ptr = 0;
    int unsigned rd_ptr = 0;
    logic [7:0]  mark_high = HIGH_MARK_RESET;
    logic [7:0]  mark_low = LOW_MARK_RESET;

    bit          src_gaps = 1'b1;
    bit          sink_stalls = 1'b1;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned stuck_cycles = 0;
    int unsigned err_count = 0;

    rx_fifo_xon_xoff_flow_core uut (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_rx_result fifo_predict(input logic kind, input logic [7:0] rx_byte);
        t_rx_result  res;
        int unsigned fill;
        res = '0;
        fill = (wr_ptr + FIFO_DEPTH - rd_ptr) % FIFO_DEPTH;
        if (kind == KIND_PUSH) begin
            if (fill >= FIFO_DEPTH - 1) begin
                res.overflow = 1'b1;
            end else begin
                ring_copy[wr_ptr] = rx_byte;
                wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
                fill++;
            end
            if (fill > mark_high) begin
                res.flow_send = 1'b1;
                res.flow_byte = XOFF_BYTE;
            end
        end else if (fill != 0) begin
            res.data_valid = 1'b1;
            res.data_byte = ring_copy[rd_ptr];
            rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
            fill--;
            if (fill < mark_low) begin
                res.flow_send = 1'b1;
                res.flow_byte = XON_BYTE;
            end
        end
        res.fill_level = (fill > 255) ? 8'hFF : 8'(fill);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        err_count++;
        if (err_count <= 100)
            $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
    endtask

    task automatic check_result(input t_rx_result got);
        t_rx_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("result with nothing expected", 32'(got), 0);
        end else begin
            want = pending_results.pop_front();
            if (got.data_valid !== want.data_valid)
                report_mismatch("data_valid", got.data_valid, want.data_valid);
            if (got.data_byte !== want.data_byte)
                report_mismatch("data_byte", got.data_byte, want.data_byte);
            if (got.flow_send !== want.flow_send)
                report_mismatch("flow_send", got.flow_send, want.flow_send);
            if (got.flow_byte !== want.flow_byte)
                report_mismatch("flow_byte", got.flow_byte, want.flow_byte);
            if (got.overflow !== want.overflow)
                report_mismatch("overflow", got.overflow, want.overflow);
            if (got.fill_level !== want.fill_level)
                report_mismatch("fill_level", got.fill_level, want.fill_level);
        end
    endtask

    task automatic add_item(input logic kind, input logic [7:0] rx_byte);
        rx_items.push_back('{kind: kind, rx_byte: rx_byte});
    endtask

    task automatic add_random(input int unsigned count, input int unsigned push_pct);
        repeat (count) begin
            add_item(($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP,
                     8'($urandom));
        end
    endtask

    task automatic add_fill_drain(input int unsigned count);
        repeat (count) add_item(KIND_PUSH, 8'($urandom));
        repeat (count) add_item(KIND_POP, 8'($urandom));
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (rx_items.size() != 0 || i_valid || pending_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic reg_idx, input logic [7:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'(4 * int'(reg_idx));
        pwdata <= {24'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_idx == REG_HIGH_MARK)
            mark_high = value;
        else
            mark_low = value;
    endtask

    task automatic set_marks(input logic [7:0] high, input logic [7:0] low);
        apb_write(REG_HIGH_MARK, high);
        apb_write(REG_LOW_MARK, low);
    endtask

    // Input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                pending_results.push_back(fifo_predict(i_kind, i_rx_byte));
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    gap_left = gap_left - 1;
                    i_valid <= 1'b0;
                end else if (rx_items.size() != 0) begin
                    next_item = rx_items.pop_front();
                    i_valid <= 1'b1;
                    i_kind <= next_item.kind;
                    i_rx_byte <= next_item.rx_byte;
                    gap_left = src_gaps ? idle_len() : 0;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall)
                check_result({o_data_valid, o_data_byte, o_flow_send, o_flow_byte,
                              o_overflow, o_fill_level});
            if (stall_left != 0) begin
                stall_left = stall_left - 1;
                i_stall <= 1'b1;
            end else begin
                stall_left = sink_stalls ? idle_len() : 0;
                i_stall <= (stall_left != 0);
                if (stall_left != 0)
                    stall_left = stall_left - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("rx_fifo_xon_xoff_flow_core test failed");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // pop on empty, extreme bytes, drain past the low mark
        add_item(KIND_POP, 8'hFF);
        add_item(KIND_PUSH, 8'h00);
        add_item(KIND_PUSH, 8'hFF);
        add_item(KIND_PUSH, 8'hA5);
        add_item(KIND_PUSH, 8'h5A);
        repeat (5) add_item(KIND_POP, 8'h00);
        wait_idle();

        set_marks(8'd0, 8'd255);
        add_item(KIND_PUSH, 8'h3C);
        add_item(KIND_PUSH, 8'hC3);
        repeat (3) add_item(KIND_POP, 8'h00);
        wait_idle();

        set_marks(8'd255, 8'd0);
        add_item(KIND_PUSH, 8'h01);
        add_item(KIND_PUSH, 8'h80);
        repeat (3) add_item(KIND_POP, 8'h7F);
        wait_idle();

        // fill past full, then drain past empty
        set_marks(8'd254, 8'd1);
        add_fill_drain(258);
        wait_idle();

        src_gaps = 1'b0;
        sink_stalls = 1'b0;
        set_marks(8'd40, 8'd20);
        add_random(150, 80);
        for (int p = 0; p < 5; p++) begin
            wait_idle();
            src_gaps = $urandom_range(0, 3) != 0;
            sink_stalls = $urandom_range(0, 3) != 0;
            set_marks(8'($urandom_range(0, 96)), 8'($urandom_range(0, 96)));
            add_random(150, $urandom_range(30, 75));
        end
        wait_idle();
        repeat (8) @(posedge i_clk);

        if (err_count == 0)
            $display("rx_fifo_xon_xoff_flow_core test passed");
        else
            $display("rx_fifo_xon_xoff_flow_core test failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
sv/rxff_pkg.sv
sv/rxff_ctrl.sv
sv/rxff_dp.sv
sv/rx_fifo_xon_xoff_flow_core.sv
tb/tb.sv
